// ===== sv/lrdc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrdc_pkg
// Types, codes and helpers shared by the log record deframer/checker.
// ----------------------------------------------------------------------------
package lrdc_pkg;

   localparam int OFFSET_BITS_DEFAULT = 40;
   localparam int OUT_OFFSET_W        = 40;
   localparam int LEN_W               = 27;
   localparam int TYPE_W              = 16;
   localparam int CSR_ADDR_W          = 2;
   localparam int CSR_DATA_W          = 27;
   localparam int HDR_BYTES           = 16;
   localparam int HDR_CNT_W           = $clog2(HDR_BYTES);

   localparam logic [31:0]       LOG_MAGIC    = 32'h524B_5657;
   localparam logic [15:0]       LOG_VERSION  = 16'd1;
   localparam logic [31:0]       FNV_BASIS    = 32'd2166136261;
   localparam logic [LEN_W-1:0]  MAXLEN_RESET = LEN_W'(64 * 1024 * 1024);
   localparam logic [TYPE_W-1:0] TYPE1_RESET  = 16'd1;
   localparam logic [TYPE_W-1:0] TYPE2_RESET  = 16'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_MAX_PAYLOAD_LEN  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FIRST_TYPE_CODE  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SECOND_TYPE_CODE = 2'd2;

   localparam logic [3:0] ST_BUSY       = 4'd0;
   localparam logic [3:0] ST_GOOD       = 4'd1;
   localparam logic [3:0] ST_BAD_MAGIC  = 4'd2;
   localparam logic [3:0] ST_BAD_LEN    = 4'd3;
   localparam logic [3:0] ST_SUM_FATAL  = 4'd4;
   localparam logic [3:0] ST_BAD_TYPE   = 4'd5;
   localparam logic [3:0] ST_TORN_TAIL  = 4'd6;
   localparam logic [3:0] ST_TAIL_SUM   = 4'd7;
   localparam logic [3:0] ST_CLEAN_END  = 4'd8;
   localparam logic [3:0] ST_HALTED     = 4'd9;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]              status;
      logic [7:0]              payload_byte;
      logic                    payload_valid;
      logic [TYPE_W-1:0]       record_type;
      logic [LEN_W-1:0]        record_length;
      logic [OUT_OFFSET_W-1:0] valid_offset;
   } rsp_type;

   // FNV-1a step; the prime 2^24 + 2^8 + 0x93 becomes shifts and adds
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
   endfunction

endpackage

// ===== sv/lrdc_out_buf.sv =====
// ----------------------------------------------------------------------------
// lrdc_out_buf
// Result register with a skid entry; full goes high only while two results wait.
// ----------------------------------------------------------------------------
module lrdc_out_buf
   import lrdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_data_ff;

endmodule

// ===== sv/log_record_deframer_checker_core.sv =====
// ----------------------------------------------------------------------------
// log_record_deframer_checker_core
// Deframes a write-ahead log byte stream and verifies each record.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_stall is low (a file byte or end of
// file) and returns exactly one result for each, registered in the output
// buffer. Header decode and the FNV-1a update are combinational, so the
// sustained rate is one byte per clock unless stalled. Two results can be
// held at the output; req_stall rises only while both wait on rsp_stall.
module log_record_deframer_checker_core
   import lrdc_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam logic PH_HEADER  = 1'b0;
   localparam logic PH_PAYLOAD = 1'b1;

   logic [LEN_W-1:0]          max_len_ff;
   logic [TYPE_W-1:0]         type1_ff, type2_ff;

   logic                      phase_ff, phase_in;
   logic [HDR_BYTES-1:0][7:0] hdr_ff, hdr_in;
   logic [HDR_CNT_W-1:0]      hcnt_ff, hcnt_in;
   logic [LEN_W-1:0]          left_ff, left_in;
   logic [31:0]               hash_ff, hash_in;
   logic [OFFSET_BITS-1:0]    pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]    good_ff, good_in;
   logic                      pend_ff, pend_in;
   logic                      stop_ff, stop_in;
   logic [TYPE_W-1:0]         cur_type_ff, cur_type_in;
   logic [LEN_W-1:0]          cur_len_ff, cur_len_in;
   logic [31:0]               cur_sum_ff, cur_sum_in;

   logic                      accept;
   rsp_type                   result;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAXLEN_RESET;
         type1_ff   <= TYPE1_RESET;
         type2_ff   <= TYPE2_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            REG_MAX_PAYLOAD_LEN:  max_len_ff <= csr_wr_data[LEN_W-1:0];
            REG_FIRST_TYPE_CODE:  type1_ff   <= csr_wr_data[TYPE_W-1:0];
            REG_SECOND_TYPE_CODE: type2_ff   <= csr_wr_data[TYPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [31:0] magic;
      logic [15:0] ver;
      logic [31:0] len;
      logic [31:0] chk_hash;
      logic [31:0] chk_sum;
      logic [15:0] chk_type;
      logic        finish;

      b        = req_payload.data_byte;
      magic    = {hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
      ver      = {hdr_ff[5], hdr_ff[4]};
      len      = {hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]};
      chk_hash = FNV_BASIS;
      chk_sum  = {b, hdr_ff[14], hdr_ff[13], hdr_ff[12]};
      chk_type = {hdr_ff[7], hdr_ff[6]};
      finish   = 1'b0;

      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      hcnt_in     = hcnt_ff;
      left_in     = left_ff;
      hash_in     = hash_ff;
      pos_in      = pos_ff;
      good_in     = good_ff;
      pend_in     = pend_ff;
      stop_in     = stop_ff;
      cur_type_in = cur_type_ff;
      cur_len_in  = cur_len_ff;
      cur_sum_in  = cur_sum_ff;

      result               = '0;
      result.status        = ST_BUSY;

      if (accept) begin
         priority if (stop_ff) begin
            result.status = ST_HALTED;
         end else if (req_payload.cmd == CMD_EOF) begin
            stop_in = 1'b1;
            priority if (pend_ff) result.status = ST_TAIL_SUM;
            else if (phase_ff == PH_HEADER && hcnt_ff == '0) result.status = ST_CLEAN_END;
            else result.status = ST_TORN_TAIL;
         end else if (pend_ff) begin
            result.status = ST_SUM_FATAL;
            stop_in       = 1'b1;
         end else if (phase_ff == PH_HEADER) begin
            hdr_in[hcnt_ff] = b;
            hcnt_in         = hcnt_ff + HDR_CNT_W'(1);
            pos_in          = pos_ff + OFFSET_BITS'(1);
            if (hcnt_ff == HDR_CNT_W'(HDR_BYTES - 1)) begin
               cur_type_in = chk_type;
               cur_len_in  = len[LEN_W-1:0];
               cur_sum_in  = chk_sum;
               hash_in     = FNV_BASIS;
               priority if (magic != LOG_MAGIC || ver != LOG_VERSION) begin
                  result.status = ST_BAD_MAGIC;
                  stop_in       = 1'b1;
               end else if (len > {5'd0, max_len_ff}) begin
                  result.status = ST_BAD_LEN;
                  stop_in       = 1'b1;
               end else if (len == 32'd0) begin
                  finish = 1'b1;
               end else begin
                  left_in  = len[LEN_W-1:0];
                  phase_in = PH_PAYLOAD;
               end
            end
         end else begin
            result.payload_byte  = b;
            result.payload_valid = 1'b1;
            hash_in  = fnv_step(hash_ff, b);
            pos_in   = pos_ff + OFFSET_BITS'(1);
            left_in  = left_ff - LEN_W'(1);
            chk_hash = hash_in;
            chk_sum  = cur_sum_ff;
            chk_type = cur_type_ff;
            finish   = (left_ff == LEN_W'(1));
         end

         if (finish) begin
            phase_in = PH_HEADER;
            hcnt_in  = '0;
            priority if (chk_hash != chk_sum) begin
               pend_in = 1'b1;
            end else if (chk_type != type1_ff && chk_type != type2_ff) begin
               result.status = ST_BAD_TYPE;
               stop_in       = 1'b1;
            end else begin
               result.status = ST_GOOD;
               good_in       = pos_in;
            end
         end
      end

      result.record_type   = cur_type_in;
      result.record_length = cur_len_in;
      result.valid_offset  = OUT_OFFSET_W'(good_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hcnt_ff     <= '0;
         left_ff     <= '0;
         hash_ff     <= FNV_BASIS;
         pos_ff      <= '0;
         good_ff     <= '0;
         pend_ff     <= 1'b0;
         stop_ff     <= 1'b0;
         cur_type_ff <= '0;
         cur_len_ff  <= '0;
         cur_sum_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         hcnt_ff     <= hcnt_in;
         left_ff     <= left_in;
         hash_ff     <= hash_in;
         pos_ff      <= pos_in;
         good_ff     <= good_in;
         pend_ff     <= pend_in;
         stop_ff     <= stop_in;
         cur_type_ff <= cur_type_in;
         cur_len_ff  <= cur_len_in;
         cur_sum_ff  <= cur_sum_in;
      end
      hdr_ff <= hdr_in;
   end

   lrdc_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .push_data   (result),
      .full        (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sv/lrdc_checker.sv =====
// ----------------------------------------------------------------------------
// lrdc_checker
// Port-level checks on the log record deframer/checker, bound to the top level.
// ----------------------------------------------------------------------------
module lrdc_checker
   import lrdc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_payload
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result or stall visible right after reset");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result waiting");

   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.payload_valid |->
         rsp_payload.status == ST_BUSY || rsp_payload.status == ST_GOOD ||
         rsp_payload.status == ST_BAD_TYPE)
      else $error("payload byte carries an impossible status");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.payload_valid |-> rsp_payload.payload_byte == 8'd0)
      else $error("non-payload result carries a byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind log_record_deframer_checker_core lrdc_checker u_lrdc_checker (.*);
